/* rtl/core/pid_with_conditional_integration_macros.svh */
// Assertion macros for the PID controller with conditional integration
`ifndef PID_WITH_CONDITIONAL_INTEGRATION_MACROS_SVH
`define PID_WITH_CONDITIONAL_INTEGRATION_MACROS_SVH

// same-cycle implication
`define PIDCI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PIDCI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/pidci_pkg.sv */
// Shared widths, types and register codes of the PID controller
package pidci_pkg;
	localparam int DATA_W    = 32;
	localparam int LIM_W     = 31;
	localparam int ACC_W     = 48;
	localparam int ERR_W     = 33;
	localparam int PROD_W    = 62;
	localparam int QUO_W     = 47;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [DATA_W-1:0] gain_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [LIM_W-1:0]         lim_t;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ITERM_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_MIN     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_RATIO   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNLOAD_LIMIT = 3'd7;

	localparam lim_t DRIVE_LIMIT_RST = 31'd393216;
	localparam lim_t BAND_MIN_RST    = 31'd3277;
	localparam lim_t BAND_RATIO_RST  = 31'd32768;
endpackage

/* rtl/core/pidci_mul.sv */
// Multi-cycle Q16.16 multiplier: two partial products, truncate toward zero, cap
module pidci_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pidci_pkg::acc_t   a,
	input  pidci_pkg::gain_t  b,
	output logic              done,
	output pidci_pkg::prod_t  y
);
	import pidci_pkg::*;

	localparam int HALF_W  = ACC_W / 2;
	localparam int PP_W    = HALF_W + DATA_W;
	localparam int FULL_W  = ACC_W + DATA_W;
	localparam int RES_W   = FULL_W - FRAC_W;
	localparam int CAP_BIT = PROD_W - 2;

	localparam logic [1:0] STEP_LO  = 2'd0;
	localparam logic [1:0] STEP_HI  = 2'd1;
	localparam logic [1:0] STEP_FIN = 2'd2;

	logic [ACC_W-1:0]  ua_q;
	logic [DATA_W-1:0] ub_q;
	logic              neg_q;
	logic [1:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [PP_W-1:0]   lo_q;
	logic [PP_W-1:0]   hi_q;
	prod_t             y_q;
	logic [FULL_W-1:0] full;
	logic [RES_W-1:0]  res;
	logic              over;
	logic [CAP_BIT:0]  capped;

	always_comb begin
		full   = {hi_q, HALF_W'(0)} + FULL_W'(lo_q);
		res    = full[FULL_W-1:FRAC_W];
		over   = (|res[RES_W-1:CAP_BIT+1]) || (res[CAP_BIT] && (|res[CAP_BIT-1:0]));
		capped = over ? {1'b1, CAP_BIT'(0)} : res[CAP_BIT:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_LO;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= STEP_LO;
			end else if (busy_q) begin
				case (step_q)
					STEP_LO: step_q <= STEP_HI;
					STEP_HI: step_q <= STEP_FIN;
					STEP_FIN: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			ua_q  <= a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
			ub_q  <= b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
			neg_q <= a[ACC_W-1] ^ b[DATA_W-1];
		end
		if (busy_q && step_q == STEP_LO)
			lo_q <= PP_W'(ua_q[HALF_W-1:0]) * PP_W'(ub_q);
		if (busy_q && step_q == STEP_HI)
			hi_q <= PP_W'(ua_q[ACC_W-1:HALF_W]) * PP_W'(ub_q);
		if (busy_q && step_q == STEP_FIN)
			y_q <= neg_q ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
	end

	assign done = done_q;
	assign y    = y_q;
endmodule

/* rtl/core/pidci_div.sv */
// Restoring divider, one quotient bit a cycle, quotient truncated toward zero
module pidci_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pidci_pkg::acc_t   num,
	input  pidci_pkg::gain_t  den,
	output logic              done,
	output pidci_pkg::acc_t   q
);
	import pidci_pkg::*;

	localparam int STEP_W = $clog2(QUO_W);
	localparam logic [STEP_W-1:0] LAST = STEP_W'(QUO_W - 1);

	logic [DATA_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DATA_W-1:0] ud_q;
	logic              neg_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ACC_W-1:0]  un;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              ge;

	always_comb begin
		un      = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
		shifted = {rem_q, quo_q[QUO_W-1]};
		ge      = shifted >= {1'b0, ud_q};
		diff    = shifted - {1'b0, ud_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= un[QUO_W-1:0];
			ud_q  <= den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
			neg_q <= num[ACC_W-1] ^ den[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign q    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

/* rtl/core/pid_with_conditional_integration.sv */
// PID controller with conditional integration and anti-windup, top level
//
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+-----------------------
//  config  | cfg_wr_en cfg_index cfg_data              | cfg_wr_en high
//  input   | setpoint measured integral_flags          | in_valid & in_ready
//  output  | drive drive_clamped                       | out_valid & out_ready
//
// One shared multiplier and one shared divider (47 steps) run under a
// sequencer; in_ready is high only when idle. With a nonzero integral gain a
// transaction also computes the integral term; the unload check and up to two
// divisions run only when needed. A result waits in an output register; a
// stalled output only holds the sequencer in its last state. Reset sets the
// control and config registers at once, not the datapath ones; no clearing pass.
module pid_with_conditional_integration (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [pidci_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidci_pkg::DATA_W-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [pidci_pkg::DATA_W-1:0]   setpoint,
	input  logic signed [pidci_pkg::DATA_W-1:0]   measured,
	input  logic [1:0]                            integral_flags,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pidci_pkg::DATA_W-1:0]   drive,
	output logic                                  drive_clamped
);
	import pidci_pkg::*;
	`include "pid_with_conditional_integration_macros.svh"

	localparam int SUM3_W = PROD_W + 2;
	localparam int EXT_W  = ACC_W + 2;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_BAND   = 4'd1;
	localparam logic [3:0] S_P      = 4'd2;
	localparam logic [3:0] S_D      = 4'd3;
	localparam logic [3:0] S_IPRE   = 4'd4;
	localparam logic [3:0] S_DECIDE = 4'd5;
	localparam logic [3:0] S_IDELTA = 4'd6;
	localparam logic [3:0] S_UDIV   = 4'd7;
	localparam logic [3:0] S_UPD    = 4'd8;
	localparam logic [3:0] S_ITERM  = 4'd9;
	localparam logic [3:0] S_CDIV   = 4'd10;
	localparam logic [3:0] S_IFIN   = 4'd11;
	localparam logic [3:0] S_OUT    = 4'd12;

	localparam acc_t SUM_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t SUM_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	gain_t gain_p_q, gain_i_q, gain_d_q;
	lim_t  iterm_limit_q, drive_limit_q, band_min_q, band_ratio_q, unload_limit_q;

	logic [3:0]              state_q;
	logic                    issued_q;
	logic [DATA_W-1:0]       abs_sp_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [ERR_W-1:0] prev_q;
	logic [1:0]              flags_q;
	logic [QUO_W-1:0]        band_q;
	prod_t                   p_q, d_q, ipre_q, iterm_q;
	acc_t                    delta_q, num_q, sum_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                    clamped_q;
	logic                    out_valid_q;

	acc_t                    mul_a;
	gain_t                   mul_b;
	logic                    mul_start, mul_done, div_start, div_done;
	prod_t                   mul_y;
	acc_t                    div_q;
	logic                    is_mul, is_div;

	logic signed [ERR_W:0]   err_diff;
	acc_t                    err_ext;
	logic signed [SUM3_W-1:0] u_pre, drive_full, dl_pos;
	logic                    err_pos, err_neg, sum_pos, sum_neg, freeze_sat;
	logic [ERR_W-1:0]        err_mag;
	logic                    in_band, take, unload_chk;
	logic [PROD_W-1:0]       y_mag;
	logic                    y_pos, y_neg, ipre_pos, ipre_neg, opposes;
	acc_t                    usl_sh, itl_sh;
	prod_t                   itl_pos;
	logic signed [EXT_W-1:0] sum_next;
	acc_t                    sum_sat;
	logic                    out_load;
	logic signed [DATA_W:0]  drive_ext, lim_ext;

	always_comb begin
		is_mul = state_q == S_BAND || state_q == S_P || state_q == S_D || state_q == S_IPRE
			|| state_q == S_IDELTA || state_q == S_ITERM || state_q == S_IFIN;
		is_div    = state_q == S_UDIV || state_q == S_CDIV;
		mul_start = is_mul && !issued_q;
		div_start = is_div && !issued_q;

		err_diff = {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
		err_ext  = {{(ACC_W-ERR_W){err_q[ERR_W-1]}}, err_q};

		case (state_q)
			S_BAND:   mul_a = $signed({(ACC_W-DATA_W)'(0), abs_sp_q});
			S_P:      mul_a = err_ext;
			S_D:      mul_a = {{(ACC_W-ERR_W-1){err_diff[ERR_W]}}, err_diff};
			S_IDELTA: mul_a = delta_q;
			default:  mul_a = sum_q;
		endcase
		case (state_q)
			S_BAND:  mul_b = $signed({1'b0, band_ratio_q});
			S_P:     mul_b = gain_p_q;
			S_D:     mul_b = gain_d_q;
			default: mul_b = gain_i_q;
		endcase

		dl_pos  = $signed({(SUM3_W-LIM_W)'(0), drive_limit_q});
		u_pre   = SUM3_W'(p_q) + SUM3_W'(ipre_q) + SUM3_W'(d_q);
		drive_full = SUM3_W'(p_q) + SUM3_W'(iterm_q) + SUM3_W'(d_q);
		err_neg = err_q[ERR_W-1];
		err_pos = !err_q[ERR_W-1] && err_q != '0;
		sum_neg = sum_q[ACC_W-1];
		sum_pos = !sum_q[ACC_W-1] && sum_q != '0;
		freeze_sat = (u_pre > dl_pos && err_pos) || (u_pre < -dl_pos && err_neg);
		err_mag = err_neg ? ERR_W'(-err_q) : ERR_W'(err_q);
		in_band = QUO_W'(err_mag) <= band_q;
		take = (!(flags_q[0] || freeze_sat) && in_band) || (sum_pos && err_neg)
			|| (sum_neg && err_pos);
		unload_chk = take && err_q != '0 && flags_q[1] && unload_limit_q != '0
			&& gain_i_q != '0 && ipre_q != '0;

		y_neg    = mul_y[PROD_W-1];
		y_pos    = !mul_y[PROD_W-1] && mul_y != '0;
		y_mag    = y_neg ? PROD_W'(-mul_y) : PROD_W'(mul_y);
		ipre_neg = ipre_q[PROD_W-1];
		ipre_pos = !ipre_q[PROD_W-1] && ipre_q != '0;
		opposes  = (ipre_pos && y_neg) || (ipre_neg && y_pos);
		usl_sh   = $signed({1'b0, unload_limit_q, FRAC_W'(0)});
		itl_sh   = $signed({1'b0, iterm_limit_q, FRAC_W'(0)});
		itl_pos  = $signed({(PROD_W-LIM_W)'(0), iterm_limit_q});

		sum_next = EXT_W'(sum_q) + EXT_W'(delta_q);
		if (sum_next > EXT_W'(SUM_MAX))
			sum_sat = SUM_MAX;
		else if (sum_next < EXT_W'(SUM_MIN))
			sum_sat = SUM_MIN;
		else
			sum_sat = sum_next[ACC_W-1:0];

		out_load  = state_q == S_OUT && (!out_valid_q || out_ready);
		drive_ext = {drive_q[DATA_W-1], drive_q};
		lim_ext   = $signed({2'b00, drive_limit_q});
	end

	pidci_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.y      (mul_y)
	);

	pidci_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (gain_i_q),
		.done   (div_done),
		.q      (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q       <= '0;
			gain_i_q       <= '0;
			gain_d_q       <= '0;
			iterm_limit_q  <= '0;
			drive_limit_q  <= DRIVE_LIMIT_RST;
			band_min_q     <= BAND_MIN_RST;
			band_ratio_q   <= BAND_RATIO_RST;
			unload_limit_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GAIN_P:       gain_p_q       <= cfg_data;
				REG_GAIN_I:       gain_i_q       <= cfg_data;
				REG_GAIN_D:       gain_d_q       <= cfg_data;
				REG_ITERM_LIMIT:  iterm_limit_q  <= cfg_data[LIM_W-1:0];
				REG_DRIVE_LIMIT:  drive_limit_q  <= cfg_data[LIM_W-1:0];
				REG_BAND_MIN:     band_min_q     <= cfg_data[LIM_W-1:0];
				REG_BAND_RATIO:   band_ratio_q   <= cfg_data[LIM_W-1:0];
				REG_UNLOAD_LIMIT: unload_limit_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			sum_q       <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (mul_start || div_start)
				issued_q <= 1'b1;
			else if (mul_done || div_done)
				issued_q <= 1'b0;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_BAND;
				S_BAND: if (mul_done) state_q <= S_P;
				S_P:    if (mul_done) state_q <= S_D;
				S_D:    if (mul_done) state_q <= S_IPRE;
				S_IPRE: if (mul_done) state_q <= S_DECIDE;
				S_DECIDE: state_q <= unload_chk ? S_IDELTA : S_UPD;
				S_IDELTA: begin
					if (mul_done)
						state_q <= (opposes && y_mag > PROD_W'(unload_limit_q)) ? S_UDIV : S_UPD;
				end
				S_UDIV: if (div_done) state_q <= S_UPD;
				S_UPD: begin
					sum_q   <= sum_sat;
					state_q <= (gain_i_q != '0) ? S_ITERM : S_OUT;
				end
				S_ITERM: begin
					if (mul_done)
						state_q <= (mul_y > itl_pos || mul_y < -itl_pos) ? S_CDIV : S_OUT;
				end
				S_CDIV: begin
					if (div_done) begin
						sum_q   <= div_q;
						state_q <= S_IFIN;
					end
				end
				S_IFIN: if (mul_done) state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						prev_q  <= err_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			abs_sp_q <= setpoint[DATA_W-1] ? DATA_W'(-setpoint) : DATA_W'(setpoint);
			err_q    <= {setpoint[DATA_W-1], setpoint} - {measured[DATA_W-1], measured};
			flags_q  <= integral_flags;
		end
		if (state_q == S_BAND && mul_done)
			band_q <= (mul_y[QUO_W-1:0] > QUO_W'(band_min_q)) ? mul_y[QUO_W-1:0]
				: QUO_W'(band_min_q);
		if (state_q == S_P && mul_done)
			p_q <= mul_y;
		if (state_q == S_D && mul_done)
			d_q <= mul_y;
		if (state_q == S_IPRE && mul_done)
			ipre_q <= mul_y;
		if (state_q == S_DECIDE)
			delta_q <= take ? err_ext : '0;
		if (state_q == S_IDELTA && mul_done)
			num_q <= y_pos ? usl_sh : -usl_sh;
		if (state_q == S_UDIV && div_done)
			delta_q <= div_q;
		if (state_q == S_UPD && gain_i_q == '0)
			iterm_q <= '0;
		if ((state_q == S_ITERM || state_q == S_IFIN) && mul_done)
			iterm_q <= mul_y;
		if (state_q == S_ITERM && mul_done)
			num_q <= (mul_y > itl_pos) ? itl_sh : -itl_sh;
		if (out_load) begin
			if (drive_full > dl_pos) begin
				drive_q   <= $signed({1'b0, drive_limit_q});
				clamped_q <= 1'b1;
			end else if (drive_full < -dl_pos) begin
				drive_q   <= -$signed({1'b0, drive_limit_q});
				clamped_q <= 1'b1;
			end else begin
				drive_q   <= drive_full[DATA_W-1:0];
				clamped_q <= 1'b0;
			end
		end
	end

	assign in_ready      = state_q == S_IDLE;
	assign out_valid     = out_valid_q;
	assign drive         = drive_q;
	assign drive_clamped = clamped_q;

	`PIDCI_ASSERT_IMP(a_drive_in_range, out_valid_q, (drive_ext <= lim_ext) && (drive_ext >= -lim_ext), "drive beyond limit")
	`PIDCI_ASSERT_IMP(a_clamp_at_limit, out_valid_q && clamped_q, (drive_ext == lim_ext) || (drive_ext == -lim_ext), "clamped drive not at limit")
	`PIDCI_ASSERT_NXT(a_accept_starts, in_valid && in_ready, (state_q == S_BAND) && !in_ready, "transaction did not start")
endmodule
